/* hw/rtl/bdes_pkg.sv */
// ----------------------------------------------------------------------------
// bdes_pkg
// Shared types and constants for the buffer difference error statistics block.
// ----------------------------------------------------------------------------
package bdes_pkg;

  // Width of the pair counters.
  localparam int CNT_W = 32;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture the incoming pair
    logic prep;    // form difference, sum and divider start values
    logic step;    // one restoring division step
    logic update;  // fold the finished pair into the statistics
    logic emit;    // load the result register and clear the statistics
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_div;  // pair is unequal and its quotient does not saturate
    logic div_done;  // last division step is in progress
    logic last;      // captured pair is marked last
    logic out_free;  // result register can take a new result
  } dp_status_t;

endpackage

/* hw/rtl/bdes_sample_if.sv */
// ----------------------------------------------------------------------------
// bdes_sample_if
// Input channel: one pair of buffer samples per beat.
// ----------------------------------------------------------------------------
interface bdes_sample_if #(
  parameter int DATA_WIDTH = 32
) ();
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] value_a;
  logic signed [DATA_WIDTH-1:0] value_b;
  logic                         last_item;

  modport source (output valid, output value_a, output value_b, output last_item,
                  input ready);
  modport sink   (input valid, input value_a, input value_b, input last_item,
                  output ready);
endinterface

/* hw/rtl/bdes_stats_if.sv */
// ----------------------------------------------------------------------------
// bdes_stats_if
// Output channel: one statistics record per beat.
// ----------------------------------------------------------------------------
interface bdes_stats_if #(
  parameter int DATA_WIDTH = 32
) ();
  import bdes_pkg::*;

  logic                         valid;
  logic                         ready;
  logic [CNT_W-1:0]             mismatch_count;
  logic [CNT_W-1:0]             element_count;
  logic [DATA_WIDTH-1:0]        max_rel_error;
  logic signed [DATA_WIDTH-1:0] max_rel_a;
  logic signed [DATA_WIDTH-1:0] max_rel_b;
  logic [DATA_WIDTH-1:0]        min_rel_error;
  logic signed [DATA_WIDTH-1:0] min_rel_a;
  logic signed [DATA_WIDTH-1:0] min_rel_b;
  logic [DATA_WIDTH-1:0]        max_abs_error;
  logic signed [DATA_WIDTH-1:0] max_abs_a;
  logic signed [DATA_WIDTH-1:0] max_abs_b;
  logic [DATA_WIDTH-1:0]        peak_magnitude;

  modport source (output valid, input ready,
                  output mismatch_count, output element_count,
                  output max_rel_error, output max_rel_a, output max_rel_b,
                  output min_rel_error, output min_rel_a, output min_rel_b,
                  output max_abs_error, output max_abs_a, output max_abs_b,
                  output peak_magnitude);
  modport sink   (input valid, output ready,
                  input mismatch_count, input element_count,
                  input max_rel_error, input max_rel_a, input max_rel_b,
                  input min_rel_error, input min_rel_a, input min_rel_b,
                  input max_abs_error, input max_abs_a, input max_abs_b,
                  input peak_magnitude);
endinterface

/* hw/rtl/bdes_ctrl.sv */
// ----------------------------------------------------------------------------
// bdes_ctrl
// Sequencer: accept a pair, prepare, divide when needed, update, and emit on the last pair.
// ----------------------------------------------------------------------------
module bdes_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  bdes_pkg::dp_status_t   status,
  output bdes_pkg::dp_cmd_t      cmd
);
  import bdes_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PREP,
    S_DIV,
    S_UPD,
    S_EMIT
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) state <= S_PREP;
        end
        S_PREP: begin
          state <= status.need_div ? S_DIV : S_UPD;
        end
        S_DIV: begin
          if (status.div_done) state <= S_UPD;
        end
        S_UPD: begin
          state <= status.last ? S_EMIT : S_IDLE;
        end
        S_EMIT: begin
          if (status.out_free) state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // No beat is taken while reset is held.
  always_comb begin
    in_ready   = (state == S_IDLE) && !rst;
    cmd.load   = (state == S_IDLE) && !rst && in_valid;
    cmd.prep   = (state == S_PREP);
    cmd.step   = (state == S_DIV);
    cmd.update = (state == S_UPD);
    cmd.emit   = (state == S_EMIT) && status.out_free;
  end

endmodule

/* hw/rtl/bdes_datapath.sv */
// ----------------------------------------------------------------------------
// bdes_datapath
// Pair registers, radix-2 restoring divider, running statistics and the
// result register.
// ----------------------------------------------------------------------------
module bdes_datapath #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  bdes_pkg::dp_cmd_t            cmd,
  output bdes_pkg::dp_status_t         status,
  input  logic signed [DATA_WIDTH-1:0] value_a,
  input  logic signed [DATA_WIDTH-1:0] value_b,
  input  logic                         last_item,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [bdes_pkg::CNT_W-1:0]   mismatch_count,
  output logic [bdes_pkg::CNT_W-1:0]   element_count,
  output logic [DATA_WIDTH-1:0]        max_rel_error,
  output logic signed [DATA_WIDTH-1:0] max_rel_a,
  output logic signed [DATA_WIDTH-1:0] max_rel_b,
  output logic [DATA_WIDTH-1:0]        min_rel_error,
  output logic signed [DATA_WIDTH-1:0] min_rel_a,
  output logic signed [DATA_WIDTH-1:0] min_rel_b,
  output logic [DATA_WIDTH-1:0]        max_abs_error,
  output logic signed [DATA_WIDTH-1:0] max_abs_a,
  output logic signed [DATA_WIDTH-1:0] max_abs_b,
  output logic [DATA_WIDTH-1:0]        peak_magnitude
);
  import bdes_pkg::*;

  localparam int W   = DATA_WIDTH;
  localparam int NW  = DATA_WIDTH + FRAC_BITS + 1;
  localparam int CW  = $clog2(DATA_WIDTH);

  // Captured pair.
  logic signed [W-1:0] a_q;
  logic signed [W-1:0] b_q;
  logic                last_q;

  // Per-pair values.
  logic [W-1:0] diff_q;
  logic [W-1:0] den_q;
  logic         unequal_q;
  logic         sat_q;

  // Divider: remainder, and dividend bits shifting out as quotient bits shift in.
  logic [W-1:0]  rem;
  logic [W-1:0]  qd;
  logic [CW-1:0] cnt;

  // Running statistics.
  logic [CNT_W-1:0]    pairs_seen;
  logic [CNT_W-1:0]    unequal_pairs;
  logic [W-1:0]        best_rel_high;
  logic [W-1:0]        best_rel_low;
  logic [W-1:0]        best_abs;
  logic signed [W-1:0] hi_a, hi_b, lo_a, lo_b, abs_a, abs_b;
  logic [W-1:0]        running_peak;

  // Combinational terms.
  logic signed [W:0] diff_s;
  logic signed [W:0] sum_s;
  logic [W:0]        diff_neg;
  logic [W:0]        sum_neg;
  logic [W-1:0]      diff_c;
  logic [W-1:0]      sum_abs;
  logic [W-1:0]      den_c;
  logic [W-1:0]      a_u, b_u;
  logic [W-1:0]      mag_a, mag_b;
  logic [W-1:0]      peak_c;
  logic              unequal_c;
  logic [NW-1:0]     num_c;
  logic [NW-1:0]     num_hi;
  logic              sat_c;
  logic [W:0]        r2;
  logic [W:0]        r2_sub;
  logic              q_bit;
  logic [W-1:0]      rel;

  always_comb begin
    diff_s   = {a_q[W-1], a_q} - {b_q[W-1], b_q};
    sum_s    = {a_q[W-1], a_q} + {b_q[W-1], b_q};
    diff_neg = -diff_s;
    sum_neg  = -sum_s;
    diff_c   = diff_s[W] ? diff_neg[W-1:0] : diff_s[W-1:0];
    // Only the pair of two most negative values has |a+b| beyond W bits, and it is equal.
    sum_abs  = sum_s[W] ? sum_neg[W-1:0] : sum_s[W-1:0];
    den_c    = (sum_abs == '0) ? W'(1) : sum_abs;
    a_u      = a_q;
    b_u      = b_q;
    mag_a    = a_u[W-1] ? (~a_u + 1'b1) : a_u;
    mag_b    = b_u[W-1] ? (~b_u + 1'b1) : b_u;
    peak_c   = running_peak;
    if (mag_a > peak_c) peak_c = mag_a;
    if (mag_b > peak_c) peak_c = mag_b;
    unequal_c = (a_q != b_q);

    // The quotient fits W bits exactly when the dividend above its low W bits is
    // below the divisor; that upper part is then the remainder after the
    // leading all-zero quotient bits.
    num_c  = {diff_c, {(FRAC_BITS + 1){1'b0}}};
    num_hi = NW'(num_c[NW-1:W]);
    sat_c  = (num_hi >= NW'(den_c));

    r2     = {rem, qd[W-1]};
    r2_sub = r2 - {1'b0, den_q};
    q_bit  = (r2 >= {1'b0, den_q});

    rel = sat_q ? '1 : qd;
  end

  always_comb begin
    status.need_div = unequal_c && !sat_c;
    status.div_done = (cnt == '0);
    status.last     = last_q;
    status.out_free = !out_valid || out_ready;
  end

  // Pair capture and divider; payload only.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a_q    <= value_a;
      b_q    <= value_b;
      last_q <= last_item;
    end
    if (cmd.prep) begin
      diff_q    <= diff_c;
      den_q     <= den_c;
      unequal_q <= unequal_c;
      sat_q     <= sat_c;
      rem       <= num_hi[W-1:0];
      qd        <= num_c[W-1:0];
      cnt       <= CW'(DATA_WIDTH - 1);
    end else if (cmd.step) begin
      rem <= q_bit ? r2_sub[W-1:0] : r2[W-1:0];
      qd  <= {qd[W-2:0], q_bit};
      cnt <= cnt - 1'b1;
    end
  end

  // Statistics and result register.
  always_ff @(posedge clk) begin
    if (rst || cmd.emit) begin
      pairs_seen    <= '0;
      unequal_pairs <= '0;
      best_rel_high <= '0;
      best_rel_low  <= '1;
      best_abs      <= '0;
      hi_a          <= '0;
      hi_b          <= '0;
      lo_a          <= '0;
      lo_b          <= '0;
      abs_a         <= '0;
      abs_b         <= '0;
      running_peak  <= '0;
    end else begin
      if (cmd.prep) begin
        if (pairs_seen != '1) pairs_seen <= pairs_seen + 1'b1;
        if (unequal_c && (unequal_pairs != '1)) unequal_pairs <= unequal_pairs + 1'b1;
        running_peak <= peak_c;
      end
      if (cmd.update && unequal_q) begin
        if (rel > best_rel_high) begin
          best_rel_high <= rel;
          hi_a          <= a_q;
          hi_b          <= b_q;
        end
        if (rel < best_rel_low) begin
          best_rel_low <= rel;
          lo_a         <= a_q;
          lo_b         <= b_q;
        end
        if (diff_q > best_abs) begin
          best_abs <= diff_q;
          abs_a    <= a_q;
          abs_b    <= b_q;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      mismatch_count <= unequal_pairs;
      element_count  <= pairs_seen;
      max_rel_error  <= best_rel_high;
      max_rel_a      <= hi_a;
      max_rel_b      <= hi_b;
      min_rel_error  <= best_rel_low;
      min_rel_a      <= lo_a;
      min_rel_b      <= lo_b;
      max_abs_error  <= best_abs;
      max_abs_a      <= abs_a;
      max_abs_b      <= abs_b;
      peak_magnitude <= (running_peak == '0) ? W'(1) : running_peak;
    end
  end

endmodule

/* hw/rtl/buffer_diff_error_stats.sv */
// ----------------------------------------------------------------------------
// buffer_diff_error_stats
// Relative and absolute error statistics over two buffers of Q-format samples.
// ----------------------------------------------------------------------------
// Pairs arrive on the samples channel, one per beat; the pair with last_item
// set closes the run and one statistics beat follows on the stats channel.
// Each pair is accepted in the idle state and prepared in the next. An unequal
// pair whose relative error does not saturate then runs, before its update,
// through a one-bit-per-cycle restoring divider; every other pair goes from
// prepare straight to update. The next pair is not accepted until the current
// pair has been updated.
// After the last pair's update the controller enters the emit step, which
// loads the result into the output register and raises stats.valid once the
// register is free. The statistics clear as the result is loaded, and the
// next pair may enter while the result still waits.
// If the receiver stalls with a result pending, a second last pair waits in
// the emit step until the register is taken; samples.ready stays low then.
// Reset (synchronous) clears all statistics and drops both handshakes.
// ----------------------------------------------------------------------------
module buffer_diff_error_stats #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input logic         clk,
  input logic         rst,
  bdes_sample_if.sink samples,
  bdes_stats_if.source stats
);
  import bdes_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  bdes_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (samples.valid),
    .in_ready (samples.ready),
    .status   (status),
    .cmd      (cmd)
  );

  bdes_datapath #(
    .DATA_WIDTH (DATA_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .value_a        (samples.value_a),
    .value_b        (samples.value_b),
    .last_item      (samples.last_item),
    .out_valid      (stats.valid),
    .out_ready      (stats.ready),
    .mismatch_count (stats.mismatch_count),
    .element_count  (stats.element_count),
    .max_rel_error  (stats.max_rel_error),
    .max_rel_a      (stats.max_rel_a),
    .max_rel_b      (stats.max_rel_b),
    .min_rel_error  (stats.min_rel_error),
    .min_rel_a      (stats.min_rel_a),
    .min_rel_b      (stats.min_rel_b),
    .max_abs_error  (stats.max_abs_error),
    .max_abs_a      (stats.max_abs_a),
    .max_abs_b      (stats.max_abs_b),
    .peak_magnitude (stats.peak_magnitude)
  );

endmodule
